// ===== hdl/safl_pkg.sv =====
// ----------------------------------------------------------------------------
// safl_pkg
// Shared types, constants and command/status bundles for the slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package safl_pkg;

    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);

    localparam int ACTION_W = 2;
    localparam int OWNER_W  = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [LINK_W-1:0]  link_t;
    typedef logic [OWNER_W-1:0] owner_t;

    // null link: one past the last slot
    localparam link_t NIL_LINK = link_t'(SLOTS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_FIND  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_USED_HEAD,
        RD_FREE_HEAD,
        RD_TARGET,
        RD_LINK
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ALLOC,
        WR_UNLINK,
        WR_PUSH
    } wr_sel_t;

    typedef enum logic [1:0] {
        SLOT_ZERO,
        SLOT_FREE_HEAD,
        SLOT_TARGET,
        SLOT_CUR
    } slot_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC_WR,
        S_FREE_HEAD_UNLINK,
        S_FREE_WALK,
        S_FREE_TGT,
        S_FREE_PUSH,
        S_FIND_WALK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic      latch;
        rd_sel_t   rd_sel;
        wr_sel_t   wr_sel;
        logic      cur_ld_head;
        logic      cur_ld_link;
        logic      uh_ld_free;
        logic      uh_ld_link;
        logic      fh_ld_link;
        logic      fh_ld_target;
        logic      count_inc;
        logic      count_dec;
        logic      resp_ld;
        status_t   resp_status;
        slot_sel_t resp_slot;
    } safl_cmd_t;

    typedef struct packed {
        action_t action;
        logic    free_nil;
        logic    used_nil;
        logic    used_head_is_target;
        logic    link_is_target;
        logic    link_nil;
        logic    owner_match;
    } safl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/slot_allocator_free_used_lists.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_free_used_lists
// Slot allocator over 64 slots kept on linked free and used lists.
// ----------------------------------------------------------------------------
// One request is handled at a time. Allocate reads the free-list head and then
// writes it onto the used list; a failed allocate or the unused action code goes
// straight to the result. Free of the used-list head unlinks it and pushes it on
// the free list; any other free or a find walks the used list through the link
// memory, one node per cycle, over up to 64 nodes, and a successful free then
// unlinks the target before the push. The walk rate is set by the single
// registered read port of the link memory. A new request is accepted the cycle
// after the result beat is taken. No clearing pass is needed after reset.
`default_nettype none

module slot_allocator_free_used_lists (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_action,
    input  wire logic [5:0]  s_slot_index,
    input  wire logic [30:0] s_owner_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [5:0]       m_slot_out,
    output logic [6:0]       m_in_use_count,
    output logic [6:0]       m_peak_count
);

    safl_pkg::safl_cmd_t cmd;
    safl_pkg::safl_sts_t sts;

    safl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    safl_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_action       (s_action),
        .s_slot_index   (s_slot_index),
        .s_owner_id     (s_owner_id),
        .m_status       (m_status),
        .m_slot_out     (m_slot_out),
        .m_in_use_count (m_in_use_count),
        .m_peak_count   (m_peak_count)
    );

endmodule

`default_nettype wire

// ===== hdl/safl_dp.sv =====
// ----------------------------------------------------------------------------
// safl_dp
// Datapath: link and owner memories, list heads, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module safl_dp (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire safl_pkg::safl_cmd_t      cmd,
    output safl_pkg::safl_sts_t           sts,
    input  wire logic [1:0]               s_action,
    input  wire logic [5:0]               s_slot_index,
    input  wire logic [30:0]              s_owner_id,
    output logic [1:0]                    m_status,
    output logic [5:0]                    m_slot_out,
    output logic [6:0]                    m_in_use_count,
    output logic [6:0]                    m_peak_count
);

    safl_pkg::link_t  link_mem [safl_pkg::SLOTS];
    safl_pkg::owner_t owner_mem [safl_pkg::SLOTS];
    logic [safl_pkg::SLOTS-1:0] link_valid_reg;

    logic [1:0]         action_reg;
    safl_pkg::idx_t     target_reg;
    safl_pkg::owner_t   owner_reg;
    safl_pkg::link_t    free_head_reg, used_head_reg, cur_reg;
    safl_pkg::link_t    used_count_reg, peak_reg;
    safl_pkg::link_t    link_q;
    safl_pkg::owner_t   owner_q;
    safl_pkg::status_t  resp_status_reg;
    safl_pkg::idx_t     resp_slot_reg;

    safl_pkg::idx_t     rd_addr;
    safl_pkg::idx_t     wr_addr;
    safl_pkg::link_t    wr_data;
    logic               link_we, owner_we;
    safl_pkg::link_t    count_inc_val;
    safl_pkg::idx_t     resp_slot_next;

    // read address mux
    always_comb begin
        case (cmd.rd_sel)
            safl_pkg::RD_USED_HEAD: rd_addr = used_head_reg[safl_pkg::IDX_W-1:0];
            safl_pkg::RD_FREE_HEAD: rd_addr = free_head_reg[safl_pkg::IDX_W-1:0];
            safl_pkg::RD_TARGET:    rd_addr = target_reg;
            safl_pkg::RD_LINK:      rd_addr = link_q[safl_pkg::IDX_W-1:0];
            default:                rd_addr = target_reg;
        endcase
    end

    always_comb begin
        link_we  = 1'b0;
        owner_we = 1'b0;
        wr_addr  = target_reg;
        wr_data  = free_head_reg;
        case (cmd.wr_sel)
            safl_pkg::WR_ALLOC: begin
                link_we  = 1'b1;
                owner_we = 1'b1;
                wr_addr  = free_head_reg[safl_pkg::IDX_W-1:0];
                wr_data  = used_head_reg;
            end
            safl_pkg::WR_UNLINK: begin
                link_we = 1'b1;
                wr_addr = cur_reg[safl_pkg::IDX_W-1:0];
                wr_data = link_q;
            end
            safl_pkg::WR_PUSH: begin
                link_we = 1'b1;
                wr_addr = target_reg;
                wr_data = free_head_reg;
            end
            default: begin
                link_we = 1'b0;
            end
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (owner_we) begin
            owner_mem[wr_addr] <= owner_reg;
        end
        owner_q <= owner_mem[rd_addr];
        // an unwritten entry still holds its reset chain link
        link_q  <= link_valid_reg[rd_addr] ? link_mem[rd_addr]
                                           : safl_pkg::link_t'(rd_addr) + safl_pkg::link_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_valid_reg <= '0;
        end else if (link_we) begin
            link_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg <= s_action;
            target_reg <= s_slot_index;
            owner_reg  <= s_owner_id;
        end
        if (cmd.cur_ld_head) begin
            cur_reg <= used_head_reg;
        end else if (cmd.cur_ld_link) begin
            cur_reg <= link_q;
        end
    end

    assign count_inc_val = used_count_reg + safl_pkg::link_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= '0;
            used_head_reg  <= safl_pkg::NIL_LINK;
            used_count_reg <= '0;
            peak_reg       <= '0;
        end else begin
            if (cmd.fh_ld_link) begin
                free_head_reg <= link_q;
            end else if (cmd.fh_ld_target) begin
                free_head_reg <= safl_pkg::link_t'(target_reg);
            end
            if (cmd.uh_ld_free) begin
                used_head_reg <= free_head_reg;
            end else if (cmd.uh_ld_link) begin
                used_head_reg <= link_q;
            end
            if (cmd.count_inc) begin
                used_count_reg <= count_inc_val;
                if (count_inc_val > peak_reg) begin
                    peak_reg <= count_inc_val;
                end
            end else if (cmd.count_dec && used_count_reg != '0) begin
                used_count_reg <= used_count_reg - safl_pkg::link_t'(1);
            end
        end
    end

    always_comb begin
        case (cmd.resp_slot)
            safl_pkg::SLOT_ZERO:      resp_slot_next = '0;
            safl_pkg::SLOT_FREE_HEAD: resp_slot_next = free_head_reg[safl_pkg::IDX_W-1:0];
            safl_pkg::SLOT_TARGET:    resp_slot_next = target_reg;
            safl_pkg::SLOT_CUR:       resp_slot_next = cur_reg[safl_pkg::IDX_W-1:0];
            default:                  resp_slot_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.resp_ld) begin
            resp_status_reg <= cmd.resp_status;
            resp_slot_reg   <= resp_slot_next;
        end
    end

    assign sts.action              = safl_pkg::action_t'(action_reg);
    assign sts.free_nil            = (free_head_reg == safl_pkg::NIL_LINK);
    assign sts.used_nil            = (used_head_reg == safl_pkg::NIL_LINK);
    assign sts.used_head_is_target = (used_head_reg == safl_pkg::link_t'(target_reg));
    assign sts.link_is_target      = (link_q == safl_pkg::link_t'(target_reg));
    assign sts.link_nil            = (link_q == safl_pkg::NIL_LINK);
    assign sts.owner_match         = (owner_q == owner_reg);

    assign m_status       = resp_status_reg;
    assign m_slot_out     = 6'(resp_slot_reg);
    assign m_in_use_count = 7'(used_count_reg);
    assign m_peak_count   = 7'(peak_reg);

endmodule

`default_nettype wire

// ===== hdl/safl_ctrl.sv =====
// ----------------------------------------------------------------------------
// safl_ctrl
// Controller: sequences allocate, free and find over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module safl_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire safl_pkg::safl_sts_t  sts,
    output safl_pkg::safl_cmd_t       cmd
);

    safl_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= safl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            safl_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = safl_pkg::S_DISPATCH;
                end
            end
            safl_pkg::S_DISPATCH: begin
                case (sts.action)
                    safl_pkg::ACT_ALLOC: begin
                        if (sts.free_nil) begin
                            cmd.resp_ld     = 1'b1;
                            cmd.resp_status = safl_pkg::ST_FULL;
                            cmd.resp_slot   = safl_pkg::SLOT_ZERO;
                            state_next      = safl_pkg::S_RESP;
                        end else begin
                            cmd.rd_sel = safl_pkg::RD_FREE_HEAD;
                            state_next = safl_pkg::S_ALLOC_WR;
                        end
                    end
                    safl_pkg::ACT_FREE: begin
                        if (sts.used_nil) begin
                            cmd.resp_ld     = 1'b1;
                            cmd.resp_status = safl_pkg::ST_NOT_ALLOC;
                            cmd.resp_slot   = safl_pkg::SLOT_ZERO;
                            state_next      = safl_pkg::S_RESP;
                        end else if (sts.used_head_is_target) begin
                            cmd.rd_sel = safl_pkg::RD_TARGET;
                            state_next = safl_pkg::S_FREE_HEAD_UNLINK;
                        end else begin
                            cmd.rd_sel      = safl_pkg::RD_USED_HEAD;
                            cmd.cur_ld_head = 1'b1;
                            state_next      = safl_pkg::S_FREE_WALK;
                        end
                    end
                    safl_pkg::ACT_FIND: begin
                        if (sts.used_nil) begin
                            cmd.resp_ld     = 1'b1;
                            cmd.resp_status = safl_pkg::ST_NOT_FOUND;
                            cmd.resp_slot   = safl_pkg::SLOT_ZERO;
                            state_next      = safl_pkg::S_RESP;
                        end else begin
                            cmd.rd_sel      = safl_pkg::RD_USED_HEAD;
                            cmd.cur_ld_head = 1'b1;
                            state_next      = safl_pkg::S_FIND_WALK;
                        end
                    end
                    default: begin
                        // unused action: report counts only
                        cmd.resp_ld     = 1'b1;
                        cmd.resp_status = safl_pkg::ST_OK;
                        cmd.resp_slot   = safl_pkg::SLOT_ZERO;
                        state_next      = safl_pkg::S_RESP;
                    end
                endcase
            end
            safl_pkg::S_ALLOC_WR: begin
                cmd.wr_sel      = safl_pkg::WR_ALLOC;
                cmd.uh_ld_free  = 1'b1;
                cmd.fh_ld_link  = 1'b1;
                cmd.count_inc   = 1'b1;
                cmd.resp_ld     = 1'b1;
                cmd.resp_status = safl_pkg::ST_OK;
                cmd.resp_slot   = safl_pkg::SLOT_FREE_HEAD;
                state_next      = safl_pkg::S_RESP;
            end
            safl_pkg::S_FREE_HEAD_UNLINK: begin
                cmd.uh_ld_link = 1'b1;
                state_next     = safl_pkg::S_FREE_PUSH;
            end
            safl_pkg::S_FREE_WALK: begin
                // cur holds the candidate predecessor, link_q its next link
                if (sts.link_is_target) begin
                    cmd.rd_sel = safl_pkg::RD_TARGET;
                    state_next = safl_pkg::S_FREE_TGT;
                end else if (sts.link_nil) begin
                    cmd.resp_ld     = 1'b1;
                    cmd.resp_status = safl_pkg::ST_NOT_ALLOC;
                    cmd.resp_slot   = safl_pkg::SLOT_ZERO;
                    state_next      = safl_pkg::S_RESP;
                end else begin
                    cmd.rd_sel      = safl_pkg::RD_LINK;
                    cmd.cur_ld_link = 1'b1;
                end
            end
            safl_pkg::S_FREE_TGT: begin
                cmd.wr_sel = safl_pkg::WR_UNLINK;
                state_next = safl_pkg::S_FREE_PUSH;
            end
            safl_pkg::S_FREE_PUSH: begin
                cmd.wr_sel       = safl_pkg::WR_PUSH;
                cmd.fh_ld_target = 1'b1;
                cmd.count_dec    = 1'b1;
                cmd.resp_ld      = 1'b1;
                cmd.resp_status  = safl_pkg::ST_OK;
                cmd.resp_slot    = safl_pkg::SLOT_TARGET;
                state_next       = safl_pkg::S_RESP;
            end
            safl_pkg::S_FIND_WALK: begin
                if (sts.owner_match) begin
                    cmd.resp_ld     = 1'b1;
                    cmd.resp_status = safl_pkg::ST_OK;
                    cmd.resp_slot   = safl_pkg::SLOT_CUR;
                    state_next      = safl_pkg::S_RESP;
                end else if (sts.link_nil) begin
                    cmd.resp_ld     = 1'b1;
                    cmd.resp_status = safl_pkg::ST_NOT_FOUND;
                    cmd.resp_slot   = safl_pkg::SLOT_ZERO;
                    state_next      = safl_pkg::S_RESP;
                end else begin
                    cmd.rd_sel      = safl_pkg::RD_LINK;
                    cmd.cur_ld_link = 1'b1;
                end
            end
            safl_pkg::S_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = safl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = safl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/safl_sva_chk.sv =====
// ----------------------------------------------------------------------------
// safl_sva_chk
// Port-level checks for the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module safl_sva_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_status,
    input wire logic [5:0]  m_slot_out,
    input wire logic [6:0]  m_in_use_count,
    input wire logic [6:0]  m_peak_count
);

    // result beat holds while stalled
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot_out)
            && $stable(m_in_use_count) && $stable(m_peak_count))
        else $error("result beat changed while stalled");

    // one request in flight: never taking input while a result is pending
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_in_use_count <= m_peak_count)
        else $error("in-use count above peak");

    a_err_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != safl_pkg::ST_OK |-> m_slot_out == 6'd0)
        else $error("nonzero slot on error status");

    // a taken result beat is not repeated on the next cycle
    a_resp_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result valid held after beat taken");

endmodule

bind slot_allocator_free_used_lists safl_sva_chk u_safl_sva_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_slot_out     (m_slot_out),
    .m_in_use_count (m_in_use_count),
    .m_peak_count   (m_peak_count)
);

`default_nettype wire
